/* hw/rtl/amcc_pkg.sv */
// Shared types and constants for the adaptive Morse carrier classifier.
package amcc_pkg;

    // Event codes carried on the result channel
    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_DOT    = 3'd1,
        EV_DASH   = 3'd2,
        EV_LETTER = 3'd3,
        EV_WORD   = 3'd4
    } t_event;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_MIN_MARK = 2'd0,
        CFG_SQUELCH  = 2'd1,
        CFG_RADIO    = 2'd2
    } t_cfg_idx;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int MIN_MARK_W = 10;
    localparam int SQUELCH_W  = 16;
    localparam int TIME_W     = 32;
    localparam int UNIT_W     = 9;

    localparam logic [MIN_MARK_W-1:0] MIN_MARK_RESET = 10'd10;
    localparam logic [SQUELCH_W-1:0]  SQUELCH_RESET  = 16'd3000;

    localparam logic [UNIT_W-1:0] UNIT_RESET = 9'd100;
    localparam logic [UNIT_W-1:0] UNIT_MIN   = 9'd30;
    localparam logic [UNIT_W-1:0] UNIT_MAX   = 9'd400;

    // Mark lengths are saturated to 14 bits before learning; anything that
    // long already pulls the unit past the upper clamp.
    localparam int               HELD_W   = 14;
    localparam logic [HELD_W-1:0] HELD_SAT = '1;

    // x / 3 == (x * 21846) >> 16, exact for x below 2^15
    localparam logic [15:0] DIV3_RECIP = 16'd21846;
    localparam int          DIV3_SHIFT = 16;

    // One polled sample
    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              carrier_level;
        logic              receive_mode;
    } t_poll;

    // Configuration register set
    typedef struct packed {
        logic [MIN_MARK_W-1:0] min_mark_ms;
        logic [SQUELCH_W-1:0]  squelch_idle_ms;
        logic                  radio_present;
    } t_cfg;

endpackage

/* hw/rtl/adaptive_morse_carrier_classifier.sv */
// Top level: handshake stages, configuration registers and the classifier core.
//
//  channel  | direction | handshake                 | beat contents
//  ---------+-----------+---------------------------+--------------------------------
//  in       | input     | i_in_valid / o_in_ready   | now_ms, carrier_level, receive_mode
//  out      | output    | o_out_valid / i_out_ready | event_code
//  cfg      | input     | i_cfg_we (no wait)        | i_cfg_addr, i_cfg_wdata
//
//  Each beat passes through the input register, then the result register.
//  One beat per cycle is sustained while i_out_ready holds; state updates on each beat.
//  Reset is synchronous, active low; it restores config defaults and a 100 ms unit.
//  A stalled result holds the result register; the input register keeps taking
//  a beat until it is also full, then o_in_ready drops.
module adaptive_morse_carrier_classifier (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [amcc_pkg::TIME_W-1:0]         i_now_ms,
    input  logic                                i_carrier_level,
    input  logic                                i_receive_mode,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [2:0]                          o_event_code,
    input  logic                                i_cfg_we,
    input  logic [amcc_pkg::CFG_IDX_W-1:0]      i_cfg_addr,
    input  logic [amcc_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);
    import amcc_pkg::*;

    logic   r_in_valid;
    t_poll  r_poll;
    logic   r_out_valid;
    t_event r_event;
    t_cfg   r_cfg;
    t_event core_event;
    logic   adv;

    // The input stage moves on whenever the result slot is free or draining
    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_poll.now_ms        <= i_now_ms;
            r_poll.carrier_level <= i_carrier_level;
            r_poll.receive_mode  <= i_receive_mode;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_mark_ms     <= MIN_MARK_RESET;
            r_cfg.squelch_idle_ms <= SQUELCH_RESET;
            r_cfg.radio_present   <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_MIN_MARK: r_cfg.min_mark_ms     <= i_cfg_wdata[MIN_MARK_W-1:0];
                CFG_SQUELCH:  r_cfg.squelch_idle_ms <= i_cfg_wdata[SQUELCH_W-1:0];
                CFG_RADIO:    r_cfg.radio_present   <= i_cfg_wdata[0];
                default:      ;
            endcase
        end
    end

    amcc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_poll  (r_poll),
        .i_cfg   (r_cfg),
        .o_event (core_event)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_event <= core_event;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_event_code = r_event;

    // Checks
    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && r_out_valid && !i_out_ready))
        else $error("input stalled without a full pipeline");

    a_adv_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_out_valid)
        else $error("result lost after advance");

    a_event_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_event == EV_NONE || r_event == EV_DOT || r_event == EV_DASH ||
                         r_event == EV_LETTER || r_event == EV_WORD))
        else $error("illegal event code");

endmodule

/* hw/rtl/amcc_core.sv */
// Edge tracking, mark classification, gap detection and unit learning.
module amcc_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  amcc_pkg::t_poll i_poll,
    input  amcc_pkg::t_cfg  i_cfg,
    output amcc_pkg::t_event o_event
);
    import amcc_pkg::*;

    // Classifier state. A mark is in progress exactly when the last
    // carrier reading was high, so one bit serves both.
    logic              r_last_level, n_last_level;
    logic [TIME_W-1:0] r_mark_start, n_mark_start;
    logic [TIME_W-1:0] r_space_start, n_space_start;
    logic              r_letter_closed, n_letter_closed;
    logic              r_word_closed, n_word_closed;
    logic              r_symbol_seen, n_symbol_seen;
    logic [UNIT_W-1:0] r_unit, n_unit;

    logic                 reading;
    logic [TIME_W-1:0]    held;
    logic [TIME_W-1:0]    idle;
    logic [UNIT_W:0]      unit_x2;
    logic [UNIT_W+2:0]    unit_x6;
    logic                 is_dash;
    logic [HELD_W-1:0]    held_sat;
    logic [HELD_W+15:0]   div3_prod;
    logic [HELD_W-1:0]    target;
    logic signed [HELD_W:0] diff;
    logic signed [HELD_W:0] diff_adj;
    logic signed [HELD_W:0] pull;
    logic signed [HELD_W+1:0] unit_sum;
    logic [UNIT_W-1:0]    learned_unit;
    t_event               event_c;

    // Durations, wrap modulo 2^32
    assign reading = i_cfg.radio_present & i_poll.carrier_level;
    assign held    = i_poll.now_ms - r_mark_start;
    assign idle    = i_poll.now_ms - r_space_start;
    assign unit_x2 = {r_unit, 1'b0};
    assign unit_x6 = {r_unit, 2'b00} + {1'b0, r_unit, 1'b0};
    assign is_dash = held >= TIME_W'(unit_x2);

    // Learning target: mark length for a dot, a third of it for a dash
    assign held_sat  = (held > TIME_W'(HELD_SAT)) ? HELD_SAT : held[HELD_W-1:0];
    assign div3_prod = held_sat * DIV3_RECIP;
    assign target    = is_dash ? div3_prod[DIV3_SHIFT +: HELD_W] : held_sat;

    // unit + (target - unit) / 8, truncating toward zero, then clamp
    always_comb begin
        diff     = $signed({1'b0, target}) - $signed((HELD_W+1)'(r_unit));
        diff_adj = diff + (diff[HELD_W] ? (HELD_W+1)'(7) : (HELD_W+1)'(0));
        pull     = diff_adj >>> 3;
        unit_sum = $signed((HELD_W+2)'(r_unit)) + $signed({pull[HELD_W], pull});
        if (unit_sum < $signed((HELD_W+2)'(UNIT_MIN))) begin
            learned_unit = UNIT_MIN;
        end else if (unit_sum > $signed((HELD_W+2)'(UNIT_MAX))) begin
            learned_unit = UNIT_MAX;
        end else begin
            learned_unit = unit_sum[UNIT_W-1:0];
        end
    end

    // Next state and event for one sample
    always_comb begin
        n_last_level    = r_last_level;
        n_mark_start    = r_mark_start;
        n_space_start   = r_space_start;
        n_letter_closed = r_letter_closed;
        n_word_closed   = r_word_closed;
        n_symbol_seen   = r_symbol_seen;
        n_unit          = r_unit;
        event_c         = EV_NONE;
        if (i_poll.receive_mode) begin
            if (reading != r_last_level) begin
                n_last_level = reading;
                if (reading) begin
                    n_mark_start = i_poll.now_ms;
                end else begin
                    n_space_start = i_poll.now_ms;
                    // marks shorter than the minimum are noise
                    if (held >= TIME_W'(i_cfg.min_mark_ms)) begin
                        n_letter_closed = 1'b0;
                        n_word_closed   = 1'b0;
                        n_symbol_seen   = 1'b1;
                        n_unit          = learned_unit;
                        event_c         = is_dash ? EV_DASH : EV_DOT;
                    end
                end
            end else if (!r_last_level && r_symbol_seen) begin
                if (!r_letter_closed && idle >= TIME_W'(unit_x2)) begin
                    n_letter_closed = 1'b1;
                    event_c         = EV_LETTER;
                end else if (r_letter_closed && !r_word_closed &&
                             idle >= TIME_W'(unit_x6)) begin
                    n_word_closed = 1'b1;
                    event_c       = EV_WORD;
                end else if (idle >= TIME_W'(i_cfg.squelch_idle_ms)) begin
                    // long silence: forget the sender's speed
                    n_symbol_seen = 1'b0;
                    n_unit        = UNIT_RESET;
                end
            end
        end
    end

    assign o_event = event_c;

    // State register, updated as each beat moves to the result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_level    <= 1'b0;
            r_mark_start    <= '0;
            r_space_start   <= '0;
            r_letter_closed <= 1'b0;
            r_word_closed   <= 1'b0;
            r_symbol_seen   <= 1'b0;
            r_unit          <= UNIT_RESET;
        end else if (i_adv) begin
            r_last_level    <= n_last_level;
            r_mark_start    <= n_mark_start;
            r_space_start   <= n_space_start;
            r_letter_closed <= n_letter_closed;
            r_word_closed   <= n_word_closed;
            r_symbol_seen   <= n_symbol_seen;
            r_unit          <= n_unit;
        end
    end

    // Checks
    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_unit >= UNIT_MIN && r_unit <= UNIT_MAX)
        else $error("unit out of range");

    a_word_after_letter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_word_closed |-> r_letter_closed)
        else $error("word gap closed without letter gap");

    a_symbol_marks_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && (event_c == EV_DOT || event_c == EV_DASH)) |=> r_symbol_seen)
        else $error("symbol not recorded");

    a_no_rx_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && !i_poll.receive_mode) |=>
            ($stable(r_unit) && $stable(r_last_level) && $stable(r_symbol_seen)))
        else $error("state changed outside receive mode");

endmodule

/* tb/amcc_checker.sv */
// Result checker for the Morse carrier classifier: predicts each poll's event and compares.
`timescale 1ns / 100ps

module amcc_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [amcc_pkg::TIME_W-1:0]     i_now_ms,
    input  logic                            i_carrier_level,
    input  logic                            i_receive_mode,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [2:0]                      i_event_code,
    input  logic                            i_cfg_we,
    input  logic [amcc_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [amcc_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output int                              o_mismatches,
    output int                              o_pending
);
    import amcc_pkg::*;

    localparam int PRINT_MAX = 200;

    // Events still owed by the block, oldest first
    t_event predicted_events[$];

    // Shadow registers
    logic [MIN_MARK_W-1:0] min_mark;
    logic [SQUELCH_W-1:0]  squelch_ms;
    logic                  radio_on;

    // Shadow keying state
    logic              keyed_last;
    logic              in_mark;
    logic [TIME_W-1:0] mark_t0;
    logic [TIME_W-1:0] space_t0;
    logic              letter_done;
    logic              word_done;
    logic              have_symbol;
    logic [UNIT_W-1:0] unit_ms;

    int mismatches = 0;
    int result_idx = 0;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string what);
        if (mismatches < PRINT_MAX)
            $display("%0t ns: %s", $time, what);
        mismatches++;
    endtask

    // Classify one poll and advance the shadow state
    task automatic predict_event(input logic [TIME_W-1:0] stamp, input logic lvl,
                                 input logic rx, output t_event ev);
        logic              keyed;
        logic [TIME_W-1:0] held;
        logic [TIME_W-1:0] idle;
        logic              dash;
        longint            target;
        longint            cur;
        longint            nxt;
        ev = EV_NONE;
        if (!rx)
            return;
        keyed = radio_on && lvl;
        if (keyed != keyed_last) begin
            keyed_last = keyed;
            if (keyed) begin
                in_mark = 1'b1;
                mark_t0 = stamp;
            end else begin
                held     = stamp - mark_t0;
                in_mark  = 1'b0;
                space_t0 = stamp;
                // too short to be a symbol: noise
                if (held < 32'(min_mark))
                    return;
                letter_done = 1'b0;
                word_done   = 1'b0;
                have_symbol = 1'b1;
                dash   = held >= 32'(unit_ms) * 32'd2;
                target = dash ? longint'(held / 32'd3) : longint'(held);
                cur    = longint'(unit_ms);
                // 1/8 pull, signed division truncates toward zero
                nxt    = cur + (target - cur) / 8;
                if (nxt < longint'(UNIT_MIN))
                    nxt = longint'(UNIT_MIN);
                if (nxt > longint'(UNIT_MAX))
                    nxt = longint'(UNIT_MAX);
                unit_ms = UNIT_W'(nxt);
                ev = dash ? EV_DASH : EV_DOT;
                return;
            end
        end
        // silence: letter gap, then word gap, squelch only on a quiet step
        if (!in_mark && have_symbol) begin
            idle = stamp - space_t0;
            if (!letter_done && idle >= 32'(unit_ms) * 32'd2) begin
                letter_done = 1'b1;
                ev = EV_LETTER;
                return;
            end
            if (letter_done && !word_done && idle >= 32'(unit_ms) * 32'd6) begin
                word_done = 1'b1;
                ev = EV_WORD;
                return;
            end
            if (idle >= 32'(squelch_ms)) begin
                have_symbol = 1'b0;
                unit_ms     = UNIT_RESET;
            end
        end
    endtask

    // Watch input, result and register ports
    always @(posedge i_clk) begin : watch
        t_event ev;
        t_event want;
        if (!i_rst_n) begin
            min_mark    = MIN_MARK_RESET;
            squelch_ms  = SQUELCH_RESET;
            radio_on    = 1'b1;
            keyed_last  = 1'b0;
            in_mark     = 1'b0;
            mark_t0     = '0;
            space_t0    = '0;
            letter_done = 1'b0;
            word_done   = 1'b0;
            have_symbol = 1'b0;
            unit_ms     = UNIT_RESET;
            predicted_events.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                predict_event(i_now_ms, i_carrier_level, i_receive_mode, ev);
                predicted_events.push_back(ev);
            end
            if (i_out_valid && i_out_ready) begin
                if (predicted_events.size() == 0) begin
                    report_mismatch($sformatf("result beat %0d with nothing pending, event %0d",
                                              result_idx, i_event_code));
                end else begin
                    want = predicted_events.pop_front();
                    if (i_event_code !== want)
                        report_mismatch($sformatf("result beat %0d: event %0d, predicted %0d",
                                                  result_idx, i_event_code, want));
                end
                result_idx++;
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_MIN_MARK: min_mark   = i_cfg_wdata[MIN_MARK_W-1:0];
                    CFG_SQUELCH:  squelch_ms = i_cfg_wdata[SQUELCH_W-1:0];
                    CFG_RADIO:    radio_on   = i_cfg_wdata[0];
                    default: ;
                endcase
            end
        end
        o_pending    <= predicted_events.size();
        o_mismatches <= mismatches;
    end

endmodule

/* tb/adaptive_morse_carrier_classifier_tb.sv */
// Testbench top for the Morse carrier classifier: clock, reset, keyed stimulus and verdict.
`timescale 1ns / 100ps

module adaptive_morse_carrier_classifier_tb;
    import amcc_pkg::*;

    localparam int WAIT_MAX     = 13;
    localparam int RUN_ITEMS    = 1000;
    localparam int QUIET_LIMIT  = 500;
    localparam int DRAIN_CYCLES = 8;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  in_valid      = 1'b0;
    logic                  in_ready;
    logic [TIME_W-1:0]     now_ms        = '0;
    logic                  carrier_level = 1'b0;
    logic                  receive_mode  = 1'b0;
    logic                  out_valid;
    logic                  out_ready     = 1'b0;
    logic [2:0]            event_code;
    logic                  cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr      = CFG_MIN_MARK;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;

    int mismatches;
    int pending;
    int quiet_cycles = 0;

    // Stimulus state: key clock, sender speed, current register values
    logic [TIME_W-1:0]     key_t;
    int                    spd;
    int                    sent_items  = 0;
    int                    calm_in     = 0;
    int                    calm_out    = 0;
    logic [MIN_MARK_W-1:0] min_now     = MIN_MARK_RESET;
    logic [SQUELCH_W-1:0]  squelch_now = SQUELCH_RESET;
    logic                  radio_now   = 1'b1;

    adaptive_morse_carrier_classifier i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_now_ms        (now_ms),
        .i_carrier_level (carrier_level),
        .i_receive_mode  (receive_mode),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_event_code    (event_code),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    amcc_checker i_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_now_ms        (now_ms),
        .i_carrier_level (carrier_level),
        .i_receive_mode  (receive_mode),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_event_code    (event_code),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata),
        .o_mismatches    (mismatches),
        .o_pending       (pending)
    );

    // 20 ns clock
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watchdog: too long without any beat on either channel
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Wait per beat; now and then a calm stretch with no waiting at all
    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            calm_left = $urandom_range(16, 64);
            return 0;
        end
        return $urandom_range(0, WAIT_MAX);
    endfunction

    // Mostly receiving, sometimes not
    function automatic logic rx_draw();
        return $urandom_range(0, 15) != 0;
    endfunction

    // Result side stalls
    initial begin : result_sink
        int stall;
        forever begin
            stall = draw_wait(calm_out);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // One poll beat
    task automatic send_poll(input logic [TIME_W-1:0] stamp, input logic lvl, input logic rx);
        int gap;
        gap = draw_wait(calm_in);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        now_ms        <= stamp;
        carrier_level <= lvl;
        receive_mode  <= rx;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (rx)
            sent_items++;
    endtask

    // Carrier on for len ms, maybe polled midway, then off
    task automatic key_mark(input logic [TIME_W-1:0] len);
        send_poll(key_t, 1'b1, rx_draw());
        if ($urandom_range(0, 2) == 0)
            send_poll(key_t + len / 2, 1'b1, rx_draw());
        key_t = key_t + len;
        send_poll(key_t, 1'b0, rx_draw());
    endtask

    // Silence for len ms, polled a few times
    task automatic key_space(input logic [TIME_W-1:0] len);
        int k;
        k = $urandom_range(1, 4);
        for (int i = 1; i <= k; i++)
            send_poll(key_t + len * i / k, 1'b0, rx_draw());
        key_t = key_t + len;
    endtask

    // Stop sending and wait for every owed result
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
    endtask

    // Reprogram all registers with the block idle
    task automatic set_registers(input logic [MIN_MARK_W-1:0] mm,
                                 input logic [SQUELCH_W-1:0] sq, input logic radio);
        drain_results();
        cfg_write(CFG_MIN_MARK, CFG_DATA_W'(mm));
        cfg_write(CFG_SQUELCH, CFG_DATA_W'(sq));
        cfg_write(CFG_RADIO, CFG_DATA_W'(radio));
        @(posedge clk);
        cfg_we <= 1'b0;
        min_now     = mm;
        squelch_now = sq;
        radio_now   = radio;
    endtask

    // One random chunk of keying: mostly well-formed symbols and spaces
    task automatic key_random_step();
        int            pick;
        logic          dash;
        logic [TIME_W-1:0] len;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            if ($urandom_range(0, 15) == 0)
                spd = $urandom_range(15, 450);
            dash = 1'($urandom_range(0, 1));
            len  = dash ? 3 * spd : spd;
            len  = len - len / 4 + $urandom_range(0, len / 2);
            if (len < min_now && $urandom_range(0, 3) != 0)
                len = min_now + $urandom_range(0, spd);
            key_mark(len);
            case ($urandom_range(0, 3))
                0: key_space(spd);
                1: key_space(3 * spd);
                2: key_space(7 * spd);
                default: key_space($urandom_range(1, 10 * spd));
            endcase
        end else if (pick < 70) begin
            // noise burst at or under the floor
            key_mark($urandom_range(0, min_now));
            key_space($urandom_range(1, 4 * spd));
        end else if (pick < 80) begin
            key_t = key_t + $urandom_range(0, 50);
            send_poll(key_t, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else if (pick < 85) begin
            // clock jump anywhere, wrap included
            key_t = $urandom;
            send_poll(key_t, 1'($urandom_range(0, 1)), 1'b1);
        end else if (pick < 90) begin
            key_mark($urandom);
        end else begin
            key_space(squelch_now + $urandom_range(0, 2 * spd));
        end
    endtask

    initial begin : stimulus
        int phase;
        int phase_end;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: default registers, unit 100 ms, clock about to wrap
        key_t = 32'hFFFF_FFC0;
        send_poll(key_t, 1'b0, 1'b1);             // quiet, nothing seen yet
        send_poll(key_t, 1'b1, 1'b0);             // not receiving: ignored
        send_poll(key_t, 1'b1, 1'b1);             // mark starts before the wrap
        send_poll(key_t + 100, 1'b0, 1'b1);       // 100 ms across the wrap: dot
        key_t = key_t + 100;
        send_poll(key_t + 50, 1'b0, 1'b1);
        send_poll(key_t + 200, 1'b0, 1'b1);       // letter gap at exactly 2 units
        send_poll(key_t + 600, 1'b0, 1'b1);       // word gap at exactly 6 units
        key_t = key_t + 1000;
        send_poll(key_t, 1'b1, 1'b1);
        send_poll(key_t + 9, 1'b0, 1'b1);         // 9 ms mark below the floor: dropped
        key_t = key_t + 259;
        send_poll(key_t, 1'b1, 1'b1);
        send_poll(key_t + 300, 1'b0, 1'b1);       // dash
        key_t = key_t + 400;
        send_poll(key_t, 1'b1, 1'b1);
        send_poll(key_t + 10, 1'b0, 1'b1);        // exactly the floor: dot, unit pulled down
        key_t = key_t + 110;
        send_poll(key_t, 1'b1, 1'b1);
        key_t = key_t + 32'h8000_0000;
        send_poll(key_t, 1'b0, 1'b1);             // huge mark: dash, unit clamps high
        send_poll(key_t + 799, 1'b0, 1'b1);
        send_poll(key_t + 800, 1'b0, 1'b1);       // letter gap
        send_poll(key_t + 2399, 1'b0, 1'b1);
        send_poll(key_t + 2400, 1'b0, 1'b1);      // word gap
        send_poll(key_t + 2999, 1'b0, 1'b1);
        send_poll(key_t + 3000, 1'b0, 1'b1);      // squelch: unit back to 100
        key_t = key_t + 3000;
        send_poll(key_t, 1'b1, 1'b1);
        send_poll(key_t + 250, 1'b0, 1'b1);       // dash only if the unit was reset
        key_t = key_t + 300;
        send_poll(key_t, 1'b1, 1'b1);
        send_poll(key_t - 1, 1'b0, 1'b1);         // longest possible mark

        // Random phases, each under its own register settings
        sent_items = 0;
        phase = 0;
        spd = 100;
        while (sent_items < RUN_ITEMS) begin
            case (phase % 6)
                0: set_registers(MIN_MARK_RESET, SQUELCH_RESET, 1'b1);
                1: set_registers('0, '0, 1'b1);
                2: set_registers(10'd1000, 16'hFFFF, 1'b1);
                3: set_registers(MIN_MARK_W'($urandom_range(0, 1000)),
                                 SQUELCH_W'($urandom_range(0, 65535)), 1'b0);
                4: set_registers(MIN_MARK_W'($urandom_range(0, 40)),
                                 SQUELCH_W'($urandom_range(200, 8000)), 1'b1);
                default: set_registers(MIN_MARK_W'($urandom_range(0, 1000)),
                                       SQUELCH_W'($urandom_range(0, 65535)), 1'b1);
            endcase
            spd = $urandom_range(15, 450);
            phase_end = sent_items + (radio_now ? 120 : 40);
            while (sent_items < phase_end)
                key_random_step();
            phase++;
        end

        drain_results();
        if (mismatches == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
